### hdl/complex_integer_alu_unit_defines.svh
// ----------------------------------------------------------------------------
// complex_integer_alu_unit_defines
// Assertion macros for the complex integer ALU.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_INTEGER_ALU_UNIT_DEFINES_SVH
`define COMPLEX_INTEGER_ALU_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CIA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and constants of the complex integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;
  localparam int PART_WIDTH = 16;
  localparam int OUT_BITS   = 33;
  localparam int PROD_W     = 2 * PART_WIDTH;
  localparam int SUM_W      = PROD_W + 1;
  localparam int QW         = SUM_W;
  localparam int DIV_STEPS  = 4;
  localparam int QB_PER     = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NSTG       = 3 + DIV_STEPS + 1;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } action_t;

  typedef logic signed [PART_WIDTH-1:0] part_t;
  typedef logic signed [OUT_BITS-1:0]   out_t;
endpackage

### hdl/cia_divider.sv
// ----------------------------------------------------------------------------
// cia_divider
// Pipelined restoring divider: QB_PER quotient bits per stage, two lanes
// share the divisor. Stalls with the enclosing pipeline through en.
// ----------------------------------------------------------------------------
module cia_divider
  import cia_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [QW-1:0]     num0,
  input  logic [QW-1:0]     num1,
  input  logic [QW-1:0]     den,
  output logic [QW-1:0]     quo0,
  output logic [QW-1:0]     quo1
);
  localparam int TOT = QB_PER * DIV_STEPS;
  localparam int RW  = QW + 1;

  logic [TOT-1:0] q0_r [DIV_STEPS+1];
  logic [TOT-1:0] q1_r [DIV_STEPS+1];
  logic [RW-1:0]  r0_r [DIV_STEPS+1];
  logic [RW-1:0]  r1_r [DIV_STEPS+1];
  logic [QW-1:0]  d_r  [DIV_STEPS+1];

  // Stage 0 view of the inputs
  always_comb begin
    q0_r[0] = TOT'(num0);
    q1_r[0] = TOT'(num1);
    r0_r[0] = '0;
    r1_r[0] = '0;
    d_r[0]  = den;
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    logic [TOT-1:0] q0_nxt, q1_nxt;
    logic [RW-1:0]  r0_nxt, r1_nxt;

    // Shift in quotient bits, subtract where it fits
    always_comb begin
      logic [RW-1:0] t0, t1;
      q0_nxt = q0_r[s];
      q1_nxt = q1_r[s];
      r0_nxt = r0_r[s];
      r1_nxt = r1_r[s];
      for (int k = 0; k < QB_PER; k++) begin
        t0 = {r0_nxt[RW-2:0], q0_nxt[TOT-1]};
        t1 = {r1_nxt[RW-2:0], q1_nxt[TOT-1]};
        q0_nxt = {q0_nxt[TOT-2:0], 1'b0};
        q1_nxt = {q1_nxt[TOT-2:0], 1'b0};
        if (t0 >= {1'b0, d_r[s]}) begin
          t0 = t0 - {1'b0, d_r[s]};
          q0_nxt[0] = 1'b1;
        end
        if (t1 >= {1'b0, d_r[s]}) begin
          t1 = t1 - {1'b0, d_r[s]};
          q1_nxt[0] = 1'b1;
        end
        r0_nxt = t0;
        r1_nxt = t1;
      end
    end

    // Advance stage registers
    always_ff @(posedge clk) begin
      if (en) begin
        q0_r[s+1] <= q0_nxt;
        q1_r[s+1] <= q1_nxt;
        r0_r[s+1] <= r0_nxt;
        r1_r[s+1] <= r1_nxt;
        d_r[s+1]  <= d_r[s];
      end
    end
  end

  assign quo0 = q0_r[DIV_STEPS][QW-1:0];
  assign quo1 = q1_r[DIV_STEPS][QW-1:0];
endmodule

### hdl/complex_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// complex_integer_alu_unit
// Complex add, subtract, multiply, divide and magnitude compare on signed
// operand pairs, with full-width results.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    in_action, in_a_re, in_a_im, in_b_re, in_b_im
// out      out  out_valid/out_ready  out_res_re, out_res_im, out_status,
//                                    out_is_equal, out_mag_less, out_mag_greater
// One item per cycle while the output is not stalled; the stages are products,
// sums and magnitudes, then four divider stages, then result select.
// The pipeline advances whenever its last stage is empty or being taken.
// A stall freezes every stage; no item is lost or repeated.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "complex_integer_alu_unit_defines.svh"

module complex_integer_alu_unit
  import cia_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  part_t              in_a_re,
  input  part_t              in_a_im,
  input  part_t              in_b_re,
  input  part_t              in_b_im,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_res_re,
  output out_t               out_res_im,
  output logic               out_status,
  output logic               out_is_equal,
  output logic               out_mag_less,
  output logic               out_mag_greater
);
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [SUM_W-1:0]         mag_t;

  typedef struct packed {
    logic [2:0] act;
    logic       eq;
    out_t       as_re;
    out_t       as_im;
  } side_t;

  logic en;
  logic [NSTG-1:0] v_r;

  assign en        = !v_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[NSTG-1];

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // Stage 1: eight products, add/sub, equality
  prod_t p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_aa_r, p_ai2_r, p_bb_r, p_bi2_r;
  side_t s1_r;
  part_t ar, ai, br, bi;
  assign ar = in_a_re;
  assign ai = in_a_im;
  assign br = in_b_re;
  assign bi = in_b_im;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r  <= ar * br;
      p_ii_r  <= ai * bi;
      p_ri_r  <= ar * bi;
      p_ir_r  <= ai * br;
      p_aa_r  <= ar * ar;
      p_ai2_r <= ai * ai;
      p_bb_r  <= br * br;
      p_bi2_r <= bi * bi;
      s1_r.act   <= in_action;
      s1_r.eq    <= (ar == br) && (ai == bi);
      s1_r.as_re <= (in_action == ACT_SUB) ? out_t'(ar) - out_t'(br)
                                            : out_t'(ar) + out_t'(br);
      s1_r.as_im <= (in_action == ACT_SUB) ? out_t'(ai) - out_t'(bi)
                                            : out_t'(ai) + out_t'(bi);
    end
  end

  // Stage 2: sums of products and squared magnitudes
  sum_t  mul_re_r, mul_im_r, dn_re_r, dn_im_r;
  mag_t  ma_r, mb_r;
  side_t s2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mul_re_r <= sum_t'(p_rr_r) - sum_t'(p_ii_r);
      mul_im_r <= sum_t'(p_ri_r) + sum_t'(p_ir_r);
      dn_re_r  <= sum_t'(p_rr_r) + sum_t'(p_ii_r);
      dn_im_r  <= sum_t'(p_ir_r) - sum_t'(p_ri_r);
      ma_r     <= mag_t'(unsigned'(p_aa_r)) + mag_t'(unsigned'(p_ai2_r));
      mb_r     <= mag_t'(unsigned'(p_bb_r)) + mag_t'(unsigned'(p_bi2_r));
      s2_r     <= s1_r;
    end
  end

  // Stage 3: compares, operand magnitudes for the divider
  logic [QW-1:0] n0_r, n1_r, den_r;
  logic neg0_r, neg1_r, lt_r, gt_r;
  sum_t  mres_re_r, mres_im_r;
  side_t s3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r    <= dn_re_r[SUM_W-1];
      neg1_r    <= dn_im_r[SUM_W-1];
      n0_r      <= dn_re_r[SUM_W-1] ? QW'(-dn_re_r) : QW'(dn_re_r);
      n1_r      <= dn_im_r[SUM_W-1] ? QW'(-dn_im_r) : QW'(dn_im_r);
      den_r     <= QW'(mb_r);
      lt_r      <= ma_r < mb_r;
      gt_r      <= ma_r > mb_r;
      mres_re_r <= mul_re_r;
      mres_im_r <= mul_im_r;
      s3_r      <= s2_r;
    end
  end

  // Divider stages with the side data delayed alongside
  logic [QW-1:0] quo0, quo1;
  cia_divider u_div (
    .clk  (clk),
    .en   (en),
    .num0 (n0_r),
    .num1 (n1_r),
    .den  (den_r),
    .quo0 (quo0),
    .quo1 (quo1)
  );

  typedef struct packed {
    side_t s;
    logic  neg0;
    logic  neg1;
    logic  dz;
    logic  lt;
    logic  gt;
    sum_t  mre;
    sum_t  mim;
  } dly_t;

  dly_t dly_r [DIV_STEPS+1];
  always_comb begin
    dly_r[0] = '{s: s3_r, neg0: neg0_r, neg1: neg1_r, dz: (den_r == '0),
                 lt: lt_r, gt: gt_r, mre: mres_re_r, mim: mres_im_r};
  end
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[s+1] <= dly_r[s];
      end
    end
  end

  // Final stage: select result
  dly_t d;
  assign d = dly_r[DIV_STEPS];
  out_t re_r, im_r;
  logic st_r, eq_r, ls_r, gr_r;
  out_t re_nxt, im_nxt;
  logic st_nxt, eq_nxt, ls_nxt, gr_nxt;
  always_comb begin
    re_nxt = '0;
    im_nxt = '0;
    st_nxt = 1'b0;
    eq_nxt = 1'b0;
    ls_nxt = 1'b0;
    gr_nxt = 1'b0;
    case (d.s.act) inside
      ACT_ADD, ACT_SUB: begin
        re_nxt = d.s.as_re;
        im_nxt = d.s.as_im;
      end
      ACT_MUL: begin
        re_nxt = out_t'(d.mre);
        im_nxt = out_t'(d.mim);
      end
      ACT_DIV: begin
        if (d.dz) begin
          st_nxt = 1'b1;
        end else begin
          re_nxt = d.neg0 ? -out_t'(quo0) : out_t'(quo0);
          im_nxt = d.neg1 ? -out_t'(quo1) : out_t'(quo1);
        end
      end
      ACT_CMP: begin
        eq_nxt = d.s.eq;
        ls_nxt = d.lt;
        gr_nxt = d.gt;
      end
      default: ;
    endcase
  end

  // Hold the result while the output stalls
  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
      eq_r <= eq_nxt;
      ls_r <= ls_nxt;
      gr_r <= gr_nxt;
    end
  end

  assign out_res_re      = re_r;
  assign out_res_im      = im_r;
  assign out_status      = st_r;
  assign out_is_equal    = eq_r;
  assign out_mag_less    = ls_r;
  assign out_mag_greater = gr_r;

  `CIA_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `CIA_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid, !(out_mag_less && out_mag_greater))
  `CIA_ASSERT_IMPL(a_eq_not_less, clk, rst_n, out_valid && out_is_equal, !out_mag_less && !out_mag_greater)
  `CIA_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_res_re))
endmodule
